### rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants for the chained hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int BUCKETS     = 64;
   localparam int NODES       = 256;
   localparam int HASH_SHIFT  = 2;
   localparam int BUCKET_W    = $clog2(BUCKETS);
   localparam int NODE_W      = $clog2(NODES);
   localparam int PTR_W       = $clog2(NODES + 1);
   localparam int COUNT_W     = 9;
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NODES);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NOP    = 2'd3
   } command_type;

   typedef struct packed {
      command_type          command;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [VALUE_W-1:0]   old_value;
      logic                 pool_full;
      logic [COUNT_W-1:0]   entry_total;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD,
      ST_READ,
      ST_CHECK,
      ST_ALLOC,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic load_head;
      logic read_node;
      logic step;
      logic alloc_step;
      logic commit;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic       end_of_chain;
      logic       match;
      logic       alloc_done;
      logic       alloc_hit;
      logic       is_insert;
      logic       is_nop;
      logic       found;
   } ctl_sts_type;

endpackage

### rtl/chm_ram.sv
// ----------------------------------------------------------------------------
// chm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module chm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

### rtl/chm_ctrl.sv
// ----------------------------------------------------------------------------
// chm_ctrl
// Command sequencer: head lookup, chain walk, allocation, writeback, reply.
// ----------------------------------------------------------------------------
module chm_ctrl
   import chm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.load_head = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            if (sts.is_nop || sts.end_of_chain) begin
               state_in = sts.is_insert ? ST_ALLOC : ST_WRITE;
            end else begin
               cmd.read_node = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.match) begin
               state_in = ST_WRITE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_ALLOC: begin
            cmd.alloc_step = 1'b1;
            if (sts.alloc_done || sts.alloc_hit) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid)
      else $error("response not presented");
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped");
`endif
endmodule

### rtl/chm_datapath.sv
// ----------------------------------------------------------------------------
// chm_datapath
// Bucket heads, node memories, in-use bits, counter and reply register.
// ----------------------------------------------------------------------------
module chm_datapath
   import chm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_item,
   input  ctl_cmd_type cmd,
   output ctl_sts_type sts,
   output rsp_type     rsp_item
);
   req_type             req_ff;
   logic [BUCKETS-1:0]  head_vld_ff;
   logic [NODES-1:0]    in_use_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [PTR_W-1:0]    cur_ff, prev_ff;
   logic                found_ff;
   logic [NODE_W-1:0]   alloc_ff;
   logic                alloc_hit_ff;
   rsp_type             rsp_ff;
   logic [BUCKET_W-1:0] bucket;

   logic [BUCKET_W-1:0] head_addr;
   logic                head_we;
   logic [PTR_W-1:0]    head_wd, head_rd, head_cur;

   logic [NODE_W-1:0]   addr;
   logic                key_we, val_we, next_we;
   logic [KEY_W-1:0]    key_rd;
   logic [VALUE_W-1:0]  val_rd, val_wd;
   logic [PTR_W-1:0]    next_rd, next_wd;

   assign bucket    = BUCKET_W'(req_ff.key >> HASH_SHIFT);
   // head read starts with the incoming item so it is ready in the head cycle
   assign head_addr = cmd.load_req ? BUCKET_W'(req_item.key >> HASH_SHIFT) : bucket;
   assign head_cur  = head_vld_ff[bucket] ? head_rd : NULL_PTR;

   chm_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head (
      .clock(clock), .wr_en(head_we), .addr(head_addr), .wr_data(head_wd), .rd_data(head_rd));
   chm_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key (
      .clock(clock), .wr_en(key_we), .addr(addr), .wr_data(req_ff.key), .rd_data(key_rd));
   chm_ram #(.WIDTH(VALUE_W), .DEPTH(NODES)) u_val (
      .clock(clock), .wr_en(val_we), .addr(addr), .wr_data(val_wd), .rd_data(val_rd));
   chm_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_next (
      .clock(clock), .wr_en(next_we), .addr(addr), .wr_data(next_wd), .rd_data(next_rd));

   logic is_ins, is_rem, do_alloc;
   assign is_ins   = (req_ff.command == CMD_INSERT);
   assign is_rem   = (req_ff.command == CMD_REMOVE);
   assign do_alloc = is_ins && !found_ff && alloc_hit_ff;

   always_comb begin
      addr    = cur_ff[NODE_W-1:0];
      key_we  = 1'b0;
      val_we  = 1'b0;
      next_we = 1'b0;
      val_wd  = req_ff.value;
      next_wd = next_rd;
      head_we = 1'b0;
      head_wd = {1'b0, alloc_ff};
      if (cmd.commit) begin
         if (is_ins && found_ff) begin
            val_we = 1'b1;
         end else if (do_alloc) begin
            addr    = alloc_ff;
            key_we  = 1'b1;
            val_we  = 1'b1;
            next_we = 1'b1;
            next_wd = head_cur;
            head_we = 1'b1;
         end else if (is_rem && found_ff && prev_ff != NULL_PTR) begin
            addr    = prev_ff[NODE_W-1:0];
            next_we = 1'b1;
         end else if (is_rem && found_ff) begin
            head_we = 1'b1;
            head_wd = next_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_item;
      end
      if (cmd.load_head) begin
         cur_ff       <= head_cur;
         prev_ff      <= NULL_PTR;
         found_ff     <= 1'b0;
         alloc_ff     <= '0;
         alloc_hit_ff <= 1'b0;
      end
      if (cmd.step) begin
         prev_ff <= cur_ff;
         cur_ff  <= next_rd;
      end
      if (cmd.read_node) begin
         found_ff <= 1'b0;
      end
      if (sts.match && !cmd.step && !found_ff) begin
         found_ff <= 1'b1;
      end
      if (cmd.alloc_step && !alloc_hit_ff) begin
         if (!in_use_ff[alloc_ff]) begin
            alloc_hit_ff <= 1'b1;
         end else if (!sts.alloc_done) begin
            alloc_ff <= alloc_ff + 1'b1;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.found       <= found_ff;
         rsp_ff.old_value   <= found_ff ? val_rd : '0;
         rsp_ff.pool_full   <= is_ins && !found_ff && !alloc_hit_ff;
         rsp_ff.entry_total <= do_alloc ? count_ff + 1'b1 :
                               (is_rem && found_ff) ? count_ff - 1'b1 : count_ff;
      end
   end

   logic chk_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff      <= 1'b0;
         in_use_ff   <= '0;
         count_ff    <= '0;
         head_vld_ff <= '0;
      end else begin
         chk_ff <= cmd.read_node;
         if (head_we) begin
            head_vld_ff[bucket] <= 1'b1;
         end
         if (cmd.commit) begin
            if (do_alloc) begin
               in_use_ff[alloc_ff] <= 1'b1;
               count_ff            <= count_ff + 1'b1;
            end else if (is_rem && found_ff) begin
               in_use_ff[cur_ff[NODE_W-1:0]] <= 1'b0;
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   assign sts.end_of_chain = (cur_ff == NULL_PTR);
   assign sts.match        = chk_ff && in_use_ff[cur_ff[NODE_W-1:0]] && (key_rd == req_ff.key);
   assign sts.alloc_done   = (alloc_ff == NODE_W'(NODES - 1));
   assign sts.alloc_hit    = alloc_hit_ff;
   assign sts.is_insert    = is_ins && !found_ff;
   assign sts.is_nop       = (req_ff.command == CMD_NOP);
   assign sts.found        = found_ff;
   assign rsp_item         = rsp_ff;

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_W'($countones(in_use_ff)))
      else $error("count mismatch");
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && do_alloc |-> !in_use_ff[alloc_ff])
      else $error("alloc of used node");
   a_rem_used: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && is_rem && found_ff |-> in_use_ff[cur_ff[NODE_W-1:0]])
      else $error("remove of free node");
`endif
endmodule

### rtl/chained_hash_map_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key/value map with separately chained buckets over a fixed node pool.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one command item (insert, get, remove, nop) with key and
//   value; rsp channel returns one item per command with found, old value,
//   pool-full flag and entry count after the command.
//   One command is in flight at a time. A miss walks the whole chain and a
//   hit stops at the matching node; the next request is taken in the cycle
//   after the result is loaded. An insert of a new key adds a serial
//   free-node scan. The chain walk through the node RAMs, one registered
//   read per node, sets the rate.
//   Reset empties all buckets and frees every node; no clearing pass.
//   When the receiver stalls, the result is held in the output register;
//   the next command is taken, but its reply waits until the previous one
//   leaves.
// ----------------------------------------------------------------------------
module chained_hash_map_engine
   import chm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   chm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd));

   chm_datapath u_dp (
      .clock(clock), .reset(reset), .req_item(req_data), .cmd(cmd), .sts(sts),
      .rsp_item(rsp_data));
endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the chained hash map engine: directed and random command
// items are checked against a behavioral map model with the same node pool.
// ----------------------------------------------------------------------------
module tb_top;
   import chm_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   chained_hash_map_engine uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // map model
   int unsigned     head_of[BUCKETS];
   logic [31:0]     key_of[NODES];
   logic [31:0]     val_of[NODES];
   int unsigned     next_of[NODES];
   bit              busy_of[NODES];
   int unsigned     live_count;

   rsp_type         pending_rsp[$];
   logic [31:0]     key_pool[$];
   int              error_count;
   int              sent_count;
   int              checked_count;
   int              full_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h want %h (item %0d)", what, got, want, checked_count);
   endtask

   function automatic void map_clear();
      foreach (head_of[i]) head_of[i] = NODES;
      foreach (busy_of[i]) busy_of[i] = 1'b0;
      live_count = 0;
   endfunction

   function automatic rsp_type map_apply(input req_type r);
      rsp_type     res;
      int unsigned b, p, prev, hit, steps, n;
      res = '0;
      b = (r.key >> HASH_SHIFT) % BUCKETS;
      p = head_of[b];
      prev = NODES;
      hit = NODES;
      steps = 0;
      while (p < NODES && steps < NODES) begin
         if (busy_of[p] && key_of[p] == r.key) begin
            hit = p;
            break;
         end
         prev = p;
         p = next_of[p];
         steps++;
      end
      if (hit == NODES) prev = NODES;
      case (r.command)
         CMD_INSERT: begin
            if (hit < NODES) begin
               res.found = 1'b1;
               res.old_value = val_of[hit];
               val_of[hit] = r.value;
            end else begin
               n = NODES;
               for (int i = 0; i < NODES; i++)
                  if (!busy_of[i]) begin
                     n = i;
                     break;
                  end
               if (n < NODES) begin
                  key_of[n] = r.key;
                  val_of[n] = r.value;
                  next_of[n] = head_of[b];
                  busy_of[n] = 1'b1;
                  head_of[b] = n;
                  live_count++;
               end else begin
                  res.pool_full = 1'b1;
               end
            end
         end
         CMD_GET: begin
            if (hit < NODES) begin
               res.found = 1'b1;
               res.old_value = val_of[hit];
            end
         end
         CMD_REMOVE: begin
            if (hit < NODES) begin
               res.found = 1'b1;
               res.old_value = val_of[hit];
               if (prev < NODES) next_of[prev] = next_of[hit];
               else head_of[b] = next_of[hit];
               busy_of[hit] = 1'b0;
               if (live_count > 0) live_count--;
            end
         end
         default: ;
      endcase
      res.entry_total = live_count[8:0];
      return res;
   endfunction

   task automatic send_command(input command_type c, input logic [31:0] k,
                               input logic [31:0] v);
      req_type r;
      int      gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.command = c;
      r.key = k;
      r.value = v;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(map_apply(r));
      if (c == CMD_INSERT) key_pool.push_back(k);
      if (pending_rsp[$].pool_full) full_count++;
      sent_count++;
   endtask

   // result checker with random receiver stalls
   initial begin
      rsp_type want;
      int      stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            report("unexpected item", 32'(rsp_data), 32'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found)
               report("found", 32'(rsp_data.found), 32'(want.found));
            if (rsp_data.old_value !== want.old_value)
               report("old_value", rsp_data.old_value, want.old_value);
            if (rsp_data.pool_full !== want.pool_full)
               report("pool_full", 32'(rsp_data.pool_full), 32'(want.pool_full));
            if (rsp_data.entry_total !== want.entry_total)
               report("entry_total", 32'(rsp_data.entry_total), 32'(want.entry_total));
         end
         checked_count++;
      end
   end

   function automatic logic [31:0] pick_key();
      if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      // narrow keys all land in bucket 0 so its chain grows long
      if ($urandom_range(0, 1) == 0)
         return {22'd0, 2'($urandom_range(0, 3)), 6'd0, 2'($urandom_range(0, 3))};
      return $urandom;
   endfunction

   task automatic test_edges();
      send_command(CMD_GET, 32'h0, 32'h0);
      send_command(CMD_REMOVE, 32'h0, 32'h0);
      send_command(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
      send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
      send_command(CMD_INSERT, 32'h0000_0100, 32'h1234_5678);
      send_command(CMD_INSERT, 32'h0000_0200, 32'h9ABC_DEF0);
      send_command(CMD_GET, 32'h0, 32'h0);
      send_command(CMD_GET, 32'h0000_0100, 32'hFFFF_FFFF);
      send_command(CMD_INSERT, 32'h0, 32'h5555_AAAA);
      send_command(CMD_REMOVE, 32'h0000_0100, 32'h0);
      send_command(CMD_GET, 32'h0000_0200, 32'h0);
      send_command(CMD_REMOVE, 32'h0000_0200, 32'h0);
      send_command(CMD_REMOVE, 32'h0, 32'h0);
      send_command(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_command(CMD_GET, 32'hFFFF_FFFF, 32'h0);
      send_command(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
   endtask

   task automatic test_fill_pool();
      for (int i = 0; i < NODES + 4; i++)
         send_command(CMD_INSERT, {20'd0, 4'($urandom_range(0, 15)), 8'(i)}, $urandom);
      send_command(CMD_INSERT, key_pool[3], 32'hA5A5_5A5A);
      for (int i = 0; i < 40; i++)
         send_command(CMD_REMOVE, pick_key(), 32'h0);
      for (int i = 0; i < 40; i++)
         send_command(CMD_INSERT, pick_key(), $urandom);
   endtask

   task automatic test_random_mix();
      int          sel;
      command_type c;
      for (int i = 0; i < 500; i++) begin
         sel = $urandom_range(0, 19);
         c = sel < 8 ? CMD_INSERT : sel < 14 ? CMD_GET : sel < 19 ? CMD_REMOVE : CMD_NOP;
         send_command(c, pick_key(), $urandom);
      end
   endtask

   initial begin
      int guard;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      full_count = 0;
      map_clear();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_fill_pool();
      test_random_mix();
      req_valid <= 1'b0;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (600) @(posedge clock);
      $display("%0d commands sent, %0d replies checked, %0d pool-full inserts",
               sent_count, checked_count, full_count);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
